// ===== hdl/cfa_pkg.sv =====
// Shared types and constants for the contiguous fit allocator.
// No dependencies; imported by contiguous_fit_allocator and its testbench.
`default_nettype none

package cfa_pkg;

	localparam int HOLE_SLOTS  = 32;
	localparam int BLOCK_SLOTS = 32;
	localparam int ADDR_BITS   = 16;
	localparam int OWNER_BITS  = 8;

	localparam int MAX_SLOTS = (HOLE_SLOTS > BLOCK_SLOTS) ? HOLE_SLOTS : BLOCK_SLOTS;
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
	localparam int HIDX_W    = $clog2(HOLE_SLOTS);
	localparam int BIDX_W    = $clog2(BLOCK_SLOTS);
	localparam int SZ_W      = ADDR_BITS + 1;
	localparam int HWORD_W   = 2 * ADDR_BITS;
	localparam int BWORD_W   = 2 * ADDR_BITS + OWNER_BITS;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_ALLOC = 2'd1;
	localparam logic [1:0] ACT_FREE  = 2'd2;
	localparam logic [1:0] ACT_COAL  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_NO_OWNER = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LOAD,
		S_A_SCAN_RD,
		S_A_SCAN_EV,
		S_A_DECIDE,
		S_A_POS_RD,
		S_A_POS_EV,
		S_A_INS,
		S_F_CNT_RD,
		S_F_CNT_EV,
		S_F_CHK,
		S_F_LP_RD,
		S_F_LP_EV,
		S_F_POS_RD,
		S_F_POS_EV,
		S_F_INS,
		S_C_FIRST,
		S_C_NX_RD,
		S_C_NX_EV,
		S_H_UP_RD,
		S_H_UP_WR,
		S_H_DN_RD,
		S_H_DN_WR,
		S_B_UP_RD,
		S_B_UP_WR,
		S_B_DN_RD,
		S_B_DN_WR,
		S_FIN
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/cfa_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module cfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/contiguous_fit_allocator.sv =====
// Top level of the contiguous fit allocator: sequencer around hole and block RAMs.
// Depends on cfa_pkg and cfa_ram.
`default_nettype none

// Contiguous-region allocator. A transaction is taken when start is high and
// busy is low; its single result appears on status/address/freed_count for
// exactly one cycle with done high, and cannot be held off. The next
// transaction may be started in the cycle done is high. Every step runs
// through one registered read port per table RAM. Load writes one hole; coalesce
// merges touching holes, shifting the hole table down; allocate scans holes,
// finds the block position, shifts blocks up, inserts, and shifts holes down on
// an exact fit; free counts the owner's blocks, then per freed block runs a hole
// position scan and two table shifts. fit_policy must be written via cfg_we/
// cfg_wdata only while idle; the block itself does not enforce this. Code 3
// acts as first fit. No clearing pass is needed after reset.
module contiguous_fit_allocator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [1:0]                      cfg_wdata,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [1:0]                      action,
	input  wire logic [cfa_pkg::ADDR_BITS-1:0]   start_addr,
	input  wire logic [cfa_pkg::ADDR_BITS-1:0]   end_addr,
	input  wire logic [cfa_pkg::ADDR_BITS-1:0]   request_size,
	input  wire logic [cfa_pkg::OWNER_BITS-1:0]  owner_id,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic [15:0]                          address,
	output logic [5:0]                           freed_count
);

	import cfa_pkg::*;

	state_t state_q, state_d;

	// latched transaction
	logic [1:0]            op_q;
	logic [ADDR_BITS-1:0]  s_q, e_q, req_q;
	logic [OWNER_BITS-1:0] own_q;

	logic [1:0]       policy_q;
	logic [CNT_W-1:0] hc_q, bc_q;
	logic [CNT_W-1:0] i_q, j_q, pos_q, n_q;

	// chosen hole
	logic                 found_q;
	logic [CNT_W-1:0]     pick_q;
	logic [ADDR_BITS-1:0] pick_s_q, pick_e_q;
	logic signed [SZ_W-1:0] psize_q;

	// current hole/block under work
	logic [ADDR_BITS-1:0] cur_s_q, cur_e_q;

	logic                 done_q;
	logic [1:0]           st_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [CNT_W-1:0]     freed_q;

	// RAM ports
	logic               h_we, b_we;
	logic [HIDX_W-1:0]  h_waddr, h_raddr;
	logic [BIDX_W-1:0]  b_waddr, b_raddr;
	logic [HWORD_W-1:0] h_wdata, h_rdata;
	logic [BWORD_W-1:0] b_wdata, b_rdata;

	cfa_ram #(.WIDTH(HWORD_W), .DEPTH(HOLE_SLOTS)) u_holes (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	cfa_ram #(.WIDTH(BWORD_W), .DEPTH(BLOCK_SLOTS)) u_blocks (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// unpacked read data
	logic [ADDR_BITS-1:0]  rh_s, rh_e, rb_s, rb_e;
	logic [OWNER_BITS-1:0] rb_own;
	assign rh_s   = h_rdata[HWORD_W-1 -: ADDR_BITS];
	assign rh_e   = h_rdata[ADDR_BITS-1:0];
	assign rb_s   = b_rdata[BWORD_W-1 -: ADDR_BITS];
	assign rb_e   = b_rdata[OWNER_BITS +: ADDR_BITS];
	assign rb_own = b_rdata[OWNER_BITS-1:0];

	// datapath terms
	logic                   accept;
	logic signed [SZ_W-1:0] sz, req_s;
	logic                   fits, take, first_pol, size_eq, merge, over;
	logic [ADDR_BITS-1:0]   carve_end;
	logic [CNT_W:0]         hc_plus_n;
	logic [CNT_W:0]         j_inc;
	logic [CNT_W:0]         i_inc;

	assign accept    = start && !busy;
	assign sz        = $signed({1'b0, rh_e}) - $signed({1'b0, rh_s});
	assign req_s     = $signed({1'b0, req_q});
	assign fits      = (sz >= req_s);
	assign first_pol = (policy_q != POL_BEST) && (policy_q != POL_WORST);
	always_comb begin
		case (policy_q)
			POL_BEST:  take = fits && (!found_q || (sz < psize_q));
			POL_WORST: take = fits && (sz > psize_q);
			default:   take = fits;
		endcase
	end
	assign size_eq   = (psize_q == req_s);
	assign carve_end = ADDR_BITS'(pick_s_q + req_q);
	assign merge     = (cur_e_q == rh_s);
	assign hc_plus_n = {1'b0, hc_q} + {1'b0, n_q};
	assign over      = (hc_plus_n > (CNT_W+1)'(HOLE_SLOTS));
	assign j_inc     = {1'b0, j_q} + 1'b1;
	assign i_inc     = {1'b0, i_q} + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (action)
						ACT_LOAD:  state_d = S_LOAD;
						ACT_ALLOC: state_d = S_A_SCAN_RD;
						ACT_FREE:  state_d = S_F_CNT_RD;
						ACT_COAL:  state_d = (hc_q < CNT_W'(2)) ? S_FIN : S_C_FIRST;
						default:   state_d = S_FIN;
					endcase
				end
			end
			S_LOAD:      state_d = S_FIN;
			S_A_SCAN_RD: state_d = (i_q == hc_q) ? S_A_DECIDE : S_A_SCAN_EV;
			S_A_SCAN_EV: state_d = (fits && first_pol) ? S_A_DECIDE : S_A_SCAN_RD;
			S_A_DECIDE: begin
				state_d = (!found_q || (bc_q >= CNT_W'(BLOCK_SLOTS))) ? S_FIN : S_A_POS_RD;
			end
			S_A_POS_RD:  state_d = (i_q == bc_q) ? S_B_UP_RD : S_A_POS_EV;
			S_A_POS_EV:  state_d = (rb_s > pick_s_q) ? S_B_UP_RD : S_A_POS_RD;
			S_B_UP_RD:   state_d = (j_q == pos_q) ? S_A_INS : S_B_UP_WR;
			S_B_UP_WR:   state_d = S_B_UP_RD;
			S_A_INS:     state_d = size_eq ? S_H_DN_RD : S_FIN;
			S_H_DN_RD: begin
				if (j_inc >= {1'b0, hc_q}) begin
					state_d = (op_q == ACT_COAL) ? S_C_NX_RD : S_FIN;
				end else begin
					state_d = S_H_DN_WR;
				end
			end
			S_H_DN_WR:   state_d = S_H_DN_RD;
			S_F_CNT_RD:  state_d = (i_q == bc_q) ? S_F_CHK : S_F_CNT_EV;
			S_F_CNT_EV:  state_d = S_F_CNT_RD;
			S_F_CHK:     state_d = ((n_q == '0) || over) ? S_FIN : S_F_LP_RD;
			S_F_LP_RD:   state_d = (i_q == bc_q) ? S_FIN : S_F_LP_EV;
			S_F_LP_EV:   state_d = (rb_own == own_q) ? S_F_POS_RD : S_F_LP_RD;
			S_F_POS_RD:  state_d = (j_q == hc_q) ? S_H_UP_RD : S_F_POS_EV;
			S_F_POS_EV:  state_d = (rh_s > cur_s_q) ? S_H_UP_RD : S_F_POS_RD;
			S_H_UP_RD:   state_d = (j_q == pos_q) ? S_F_INS : S_H_UP_WR;
			S_H_UP_WR:   state_d = S_H_UP_RD;
			S_F_INS:     state_d = S_B_DN_RD;
			S_B_DN_RD:   state_d = (j_inc >= {1'b0, bc_q}) ? S_F_LP_RD : S_B_DN_WR;
			S_B_DN_WR:   state_d = S_B_DN_RD;
			S_C_FIRST:   state_d = S_C_NX_RD;
			S_C_NX_RD:   state_d = (i_inc >= {1'b0, hc_q}) ? S_FIN : S_C_NX_EV;
			S_C_NX_EV:   state_d = merge ? S_H_DN_RD : S_C_NX_RD;
			S_FIN:       state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// RAM control
	always_comb begin
		h_we    = 1'b0;
		h_waddr = '0;
		h_wdata = h_rdata;
		h_raddr = '0;
		b_we    = 1'b0;
		b_waddr = '0;
		b_wdata = b_rdata;
		b_raddr = '0;
		unique case (state_q)
			S_LOAD: begin
				h_we    = (hc_q < CNT_W'(HOLE_SLOTS));
				h_waddr = hc_q[HIDX_W-1:0];
				h_wdata = {s_q, e_q};
			end
			S_A_SCAN_RD: h_raddr = i_q[HIDX_W-1:0];
			S_A_POS_RD:  b_raddr = i_q[BIDX_W-1:0];
			S_B_UP_RD:   b_raddr = BIDX_W'(j_q - 1'b1);
			S_B_UP_WR: begin
				b_we    = 1'b1;
				b_waddr = j_q[BIDX_W-1:0];
			end
			S_A_INS: begin
				b_we    = 1'b1;
				b_waddr = pos_q[BIDX_W-1:0];
				b_wdata = {pick_s_q, carve_end, own_q};
				h_we    = !size_eq;
				h_waddr = pick_q[HIDX_W-1:0];
				h_wdata = {carve_end, pick_e_q};
			end
			S_H_DN_RD: h_raddr = j_inc[HIDX_W-1:0];
			S_H_DN_WR: begin
				h_we    = 1'b1;
				h_waddr = j_q[HIDX_W-1:0];
			end
			S_F_CNT_RD:  b_raddr = i_q[BIDX_W-1:0];
			S_F_LP_RD:   b_raddr = i_q[BIDX_W-1:0];
			S_F_POS_RD:  h_raddr = j_q[HIDX_W-1:0];
			S_H_UP_RD:   h_raddr = HIDX_W'(j_q - 1'b1);
			S_H_UP_WR: begin
				h_we    = 1'b1;
				h_waddr = j_q[HIDX_W-1:0];
			end
			S_F_INS: begin
				h_we    = 1'b1;
				h_waddr = pos_q[HIDX_W-1:0];
				h_wdata = {cur_s_q, cur_e_q};
			end
			S_B_DN_RD:   b_raddr = j_inc[BIDX_W-1:0];
			S_B_DN_WR: begin
				b_we    = 1'b1;
				b_waddr = j_q[BIDX_W-1:0];
			end
			S_C_NX_RD:   h_raddr = i_inc[HIDX_W-1:0];
			S_C_NX_EV: begin
				h_we    = merge;
				h_waddr = i_q[HIDX_W-1:0];
				h_wdata = {cur_s_q, rh_e};
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			policy_q <= POL_FIRST;
			hc_q     <= '0;
			bc_q     <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FIN);
			if (cfg_we) begin
				policy_q <= cfg_wdata;
			end
			case (state_q)
				S_LOAD:    if (hc_q < CNT_W'(HOLE_SLOTS)) hc_q <= hc_q + 1'b1;
				S_A_INS:   bc_q <= bc_q + 1'b1;
				S_F_INS:   hc_q <= hc_q + 1'b1;
				S_H_DN_RD: if (j_inc >= {1'b0, hc_q}) hc_q <= hc_q - 1'b1;
				S_B_DN_RD: if (j_inc >= {1'b0, bc_q}) bc_q <= bc_q - 1'b1;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q    <= action;
					s_q     <= start_addr;
					e_q     <= end_addr;
					req_q   <= request_size;
					own_q   <= owner_id;
					st_q    <= ST_OK;
					addr_q  <= '0;
					freed_q <= '0;
					i_q     <= '0;
					n_q     <= '0;
					found_q <= 1'b0;
					psize_q <= '1;
				end
			end
			S_LOAD: if (hc_q >= CNT_W'(HOLE_SLOTS)) st_q <= ST_FULL;
			S_A_SCAN_EV: begin
				if (take) begin
					pick_q   <= i_q;
					pick_s_q <= rh_s;
					pick_e_q <= rh_e;
					psize_q  <= sz;
					found_q  <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
			S_A_DECIDE: begin
				if (!found_q) begin
					st_q <= ST_NO_FIT;
				end else if (bc_q >= CNT_W'(BLOCK_SLOTS)) begin
					st_q <= ST_FULL;
				end
				i_q <= '0;
			end
			S_A_POS_RD: begin
				if (i_q == bc_q) begin
					pos_q <= i_q;
					j_q   <= bc_q;
				end
			end
			S_A_POS_EV: begin
				if (rb_s > pick_s_q) begin
					pos_q <= i_q;
					j_q   <= bc_q;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			S_B_UP_WR: j_q <= j_q - 1'b1;
			S_H_UP_WR: j_q <= j_q - 1'b1;
			S_H_DN_WR: j_q <= j_q + 1'b1;
			S_B_DN_WR: j_q <= j_q + 1'b1;
			S_A_INS: begin
				addr_q <= pick_s_q;
				j_q    <= pick_q;
			end
			S_F_CNT_EV: begin
				if (rb_own == own_q) n_q <= n_q + 1'b1;
				i_q <= i_q + 1'b1;
			end
			S_F_CHK: begin
				if (n_q == '0) begin
					st_q <= ST_NO_OWNER;
				end else if (over) begin
					st_q <= ST_FULL;
				end else begin
					freed_q <= n_q;
				end
				i_q <= '0;
			end
			S_F_LP_EV: begin
				if (rb_own == own_q) begin
					cur_s_q <= rb_s;
					cur_e_q <= rb_e;
					j_q     <= '0;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			S_F_POS_RD: if (j_q == hc_q) pos_q <= j_q;
			S_F_POS_EV: begin
				if (rh_s > cur_s_q) begin
					pos_q <= j_q;
					j_q   <= hc_q;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			S_F_INS: j_q <= i_q;
			S_C_FIRST: begin
				cur_s_q <= rh_s;
				cur_e_q <= rh_e;
				i_q     <= '0;
			end
			S_C_NX_EV: begin
				if (merge) begin
					cur_e_q <= rh_e;
					j_q     <= i_q + 1'b1;
				end else begin
					cur_s_q <= rh_s;
					cur_e_q <= rh_e;
					i_q     <= i_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = st_q;
	assign address     = 16'(addr_q);
	assign freed_count = 6'(freed_q);

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without a running transaction");
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted transaction not started");
	a_hole_count: assert property (@(posedge clk) disable iff (!arst_n)
		(hc_q <= CNT_W'(HOLE_SLOTS)) && (bc_q <= CNT_W'(BLOCK_SLOTS)))
		else $error("table count overflow");
	a_freed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (freed_count != 6'd0)) |-> (status == ST_OK))
		else $error("freed count with error status");
`endif

endmodule

`default_nettype wire

// ===== sim/contiguous_fit_allocator_tb.sv =====
// Testbench for contiguous_fit_allocator: directed and random transactions
// checked against an in-bench allocator predictor. Depends on cfa_pkg and contiguous_fit_allocator.
`default_nettype none

module contiguous_fit_allocator_tb;
	import cfa_pkg::*;

	localparam int STALL_LIMIT = 100000;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] address;
		logic [5:0]  freed_count;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_wdata = '0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] action = '0;
	logic [ADDR_BITS-1:0] start_addr = '0;
	logic [ADDR_BITS-1:0] end_addr = '0;
	logic [ADDR_BITS-1:0] request_size = '0;
	logic [OWNER_BITS-1:0] owner_id = '0;
	logic done;
	logic [1:0] status;
	logic [15:0] address;
	logic [5:0] freed_count;

	contiguous_fit_allocator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .action(action), .start_addr(start_addr),
		.end_addr(end_addr), .request_size(request_size), .owner_id(owner_id),
		.done(done), .status(status), .address(address), .freed_count(freed_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor copy of the allocator tables
	logic [ADDR_BITS-1:0] m_hs[HOLE_SLOTS], m_he[HOLE_SLOTS];
	logic [ADDR_BITS-1:0] m_bs[BLOCK_SLOTS], m_be[BLOCK_SLOTS];
	logic [OWNER_BITS-1:0] m_bo[BLOCK_SLOTS];
	int m_holes, m_blocks;
	logic [1:0] m_policy;

	outcome_t pending_outcomes[$];
	int errors = 0;
	int stall_cycles = 0;
	int n_sent = 0, n_ok = 0, n_nofit = 0, n_noown = 0, n_full = 0;
	bit gaps_on = 1'b1;

	function automatic longint hsize(int i);
		return longint'(m_he[i]) - longint'(m_hs[i]);
	endfunction

	function automatic void hole_insert(int pos, logic [ADDR_BITS-1:0] s,
			logic [ADDR_BITS-1:0] e);
		for (int i = m_holes; i > pos; i--) begin
			m_hs[i] = m_hs[i-1];
			m_he[i] = m_he[i-1];
		end
		m_hs[pos] = s;
		m_he[pos] = e;
		m_holes++;
	endfunction

	function automatic void hole_remove(int pos);
		for (int i = pos; i + 1 < m_holes; i++) begin
			m_hs[i] = m_hs[i+1];
			m_he[i] = m_he[i+1];
		end
		m_holes--;
	endfunction

	function automatic int choose_hole(longint req);
		int pick;
		longint psz;
		longint sz;
		pick = -1;
		psz = -1;
		for (int i = 0; i < m_holes; i++) begin
			sz = hsize(i);
			if (sz < req)
				continue;
			if (m_policy == POL_BEST) begin
				if (pick < 0 || sz < psz) begin
					pick = i;
					psz = sz;
				end
			end else if (m_policy == POL_WORST) begin
				if (sz > psz) begin
					pick = i;
					psz = sz;
				end
			end else begin
				return i;
			end
		end
		return pick;
	endfunction

	// Applies one transaction to the predictor and returns its outcome.
	function automatic outcome_t predict_outcome(logic [1:0] act,
			logic [ADDR_BITS-1:0] s, logic [ADDR_BITS-1:0] e,
			logic [ADDR_BITS-1:0] req, logic [OWNER_BITS-1:0] own);
		outcome_t o;
		int h, pos, n, i;
		logic [ADDR_BITS-1:0] base;
		o = '0;
		case (act)
			ACT_LOAD: begin
				if (m_holes >= HOLE_SLOTS)
					o.status = ST_FULL;
				else
					hole_insert(m_holes, s, e);
			end
			ACT_ALLOC: begin
				h = choose_hole(longint'(req));
				if (h < 0) begin
					o.status = ST_NO_FIT;
				end else if (m_blocks >= BLOCK_SLOTS) begin
					o.status = ST_FULL;
				end else begin
					base = m_hs[h];
					pos = 0;
					while (pos < m_blocks && m_bs[pos] <= base)
						pos++;
					for (int j = m_blocks; j > pos; j--) begin
						m_bs[j] = m_bs[j-1];
						m_be[j] = m_be[j-1];
						m_bo[j] = m_bo[j-1];
					end
					m_bs[pos] = base;
					m_be[pos] = base + req;
					m_bo[pos] = own;
					m_blocks++;
					if (hsize(h) == longint'(req))
						hole_remove(h);
					else
						m_hs[h] = base + req;
					o.address = base;
				end
			end
			ACT_FREE: begin
				n = 0;
				for (int k = 0; k < m_blocks; k++)
					if (m_bo[k] == own)
						n++;
				if (n == 0) begin
					o.status = ST_NO_OWNER;
				end else if (m_holes + n > HOLE_SLOTS) begin
					o.status = ST_FULL;
				end else begin
					i = 0;
					while (i < m_blocks) begin
						if (m_bo[i] == own) begin
							pos = 0;
							while (pos < m_holes && m_hs[pos] <= m_bs[i])
								pos++;
							hole_insert(pos, m_bs[i], m_be[i]);
							for (int k = i; k + 1 < m_blocks; k++) begin
								m_bs[k] = m_bs[k+1];
								m_be[k] = m_be[k+1];
								m_bo[k] = m_bo[k+1];
							end
							m_blocks--;
						end else begin
							i++;
						end
					end
					o.freed_count = n[5:0];
				end
			end
			default: begin
				i = 0;
				while (i + 1 < m_holes) begin
					if (m_he[i] == m_hs[i+1]) begin
						m_he[i] = m_he[i+1];
						hole_remove(i + 1);
					end else begin
						i++;
					end
				end
			end
		endcase
		return o;
	endfunction

	// result checker; done is sampled at the edge that accepts it
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$error("result with no transaction outstanding");
				errors++;
			end else begin
				want = pending_outcomes.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (address !== want.address) begin
					$error("address: expected %0d, got %0d", want.address, address);
					errors++;
				end
				if (freed_count !== want.freed_count) begin
					$error("freed_count: expected %0d, got %0d",
						want.freed_count, freed_count);
					errors++;
				end
				case (want.status)
					ST_OK: n_ok++;
					ST_NO_FIT: n_nofit++;
					ST_NO_OWNER: n_noown++;
					default: n_full++;
				endcase
			end
		end
	end

	// watchdog: cycles with no accepted transaction or result
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog expired");
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Sends one transaction; start stays high until the accepting edge.
	// start is left high afterwards; the next send or drain() decides.
	task automatic send_item(logic [1:0] act, logic [ADDR_BITS-1:0] s,
			logic [ADDR_BITS-1:0] e, logic [ADDR_BITS-1:0] req,
			logic [OWNER_BITS-1:0] own);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		start_addr <= s;
		end_addr <= e;
		request_size <= req;
		owner_id <= own;
		do
			@(posedge clk);
		while (busy);
		pending_outcomes.push_back(predict_outcome(act, s, e, req, own));
		n_sent++;
	endtask

	// Waits for every result, then a settle time before a register write.
	task automatic drain();
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_policy(logic [1:0] pol);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= pol;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_policy = pol;
	endtask

	// Directed: edge fields, every action, every status and special case.
	task automatic test_directed();
		send_item(ACT_ALLOC, 0, 0, 0, 8'h01);       // no holes: no fit
		send_item(ACT_FREE, 0, 0, 0, 8'hFF);        // unknown owner
		send_item(ACT_LOAD, 16'h0010, 16'h0010, 0, 0);   // zero-size hole
		send_item(ACT_LOAD, 16'hFFFF, 16'h0000, 0, 0);   // reversed hole
		send_item(ACT_LOAD, 16'h0100, 16'h0200, 0, 0);
		send_item(ACT_LOAD, 16'h0200, 16'hFFFF, 0, 0);
		send_item(ACT_ALLOC, 0, 0, 0, 8'hFF);       // zero request
		send_item(ACT_ALLOC, 0, 0, 16'hFFFF, 8'h00);    // too large
		send_item(ACT_ALLOC, 0, 0, 16'h0100, 8'h05);    // exact fit
		send_item(ACT_ALLOC, 0, 0, 16'h0010, 8'h05);
		send_item(ACT_COAL, 0, 0, 0, 0);
		send_item(ACT_FREE, 0, 0, 0, 8'h05);
		send_item(ACT_COAL, 0, 0, 0, 0);
		send_item(ACT_FREE, 0, 0, 0, 8'hFF);
		send_item(ACT_COAL, 0, 0, 0, 0);
		// fill the hole table
		for (int i = 0; i < HOLE_SLOTS + 1; i++)
			send_item(ACT_LOAD, 16'(i * 64), 16'(i * 64 + 8), 0, 0);
		// fill the block table with single-unit blocks
		for (int i = 0; i < BLOCK_SLOTS + 1; i++)
			send_item(ACT_ALLOC, 0, 0, 1, 8'(i % 3));
		send_item(ACT_FREE, 0, 0, 0, 8'd0);         // hole table overflow
		send_item(ACT_COAL, 0, 0, 0, 0);
	endtask

	// Random stream biased toward well-formed allocation traffic.
	task automatic test_random(int count);
		logic [15:0] s, len, req;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			s = 16'($urandom);
			len = (r % 7 == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
			req = ($urandom_range(0, 9) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 200));
			if (r < 25)
				send_item(ACT_LOAD, s, s + len, 0, 0);
			else if (r < 28)
				send_item(ACT_LOAD, s, 16'($urandom), 0, 0);
			else if (r < 65)
				send_item(ACT_ALLOC, 16'($urandom), 16'($urandom), req,
					8'($urandom_range(0, 7)));
			else if (r < 68)
				send_item(ACT_ALLOC, 0, 0, req, 8'($urandom));
			else if (r < 88)
				send_item(ACT_FREE, 16'($urandom), 0, 0,
					($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)));
			else
				send_item(ACT_COAL, 16'($urandom), 16'($urandom), 16'($urandom),
					8'($urandom));
		end
	endtask

	task automatic test_policies();
		set_policy(POL_BEST);
		test_random(500);
		set_policy(POL_WORST);
		test_random(500);
		set_policy(2'd3);      // unused code, first fit
		test_random(300);
		set_policy(POL_FIRST);
		gaps_on = 1'b0;        // tail runs back to back
		test_random(400);
	endtask

	initial begin
		m_holes = 0;
		m_blocks = 0;
		m_policy = POL_FIRST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300);
		test_policies();
		drain();
		repeat (200) @(posedge clk);
		$display("%0d transactions: %0d ok, %0d no fit, %0d no owner, %0d full",
			n_sent, n_ok, n_nofit, n_noown, n_full);
		$display("all four fit policy codes exercised");
		if (errors == 0 && pending_outcomes.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
